// ===== hdl/rbd_pkg.sv =====
// Package for the ring buffer deque: ring sizes, command and status codes, controller
// state, and the controller-to-datapath command struct. No dependencies.

package rbd_pkg;

  localparam int RING_SLOTS  = 16;
  localparam int WORD_BITS   = 32;
  localparam int CMD_BITS    = 3;
  localparam int VALUE_BITS  = WORD_BITS;
  localparam int POS_BITS    = $clog2(RING_SLOTS);
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = $clog2(RING_SLOTS);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_POP_FRONT  = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ_INDEX = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

// ===== hdl/rbd_if.sv =====
// Handshake channels of the ring buffer deque: command items in, result items out.
// Depends on rbd_pkg for field widths.

interface rbd_req_if;
  logic                            valid;
  logic                            ready;
  logic [rbd_pkg::CMD_BITS-1:0]    cmd;
  logic [rbd_pkg::VALUE_BITS-1:0]  value;
  logic [rbd_pkg::POS_BITS-1:0]    position;

  modport source (output valid, output cmd, output value, output position, input ready);
  modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

interface rbd_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [rbd_pkg::VALUE_BITS-1:0]   read_value;
  logic [rbd_pkg::STATUS_BITS-1:0]  status;
  logic                             dropped;
  logic [rbd_pkg::COUNT_BITS-1:0]   count;
  logic                             is_full;
  logic                             is_empty;

  modport source (output valid, output read_value, output status, output dropped,
                  output count, output is_full, output is_empty, input ready);
  modport sink   (input valid, input read_value, input status, input dropped,
                  input count, input is_full, input is_empty, output ready);
endinterface

// ===== hdl/rbd_ctrl.sv =====
// Controller of the ring buffer deque: sequences accept, execute and result.
// Depends on rbd_pkg.

module rbd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rbd_pkg::ctrl_cmd_t ctrl,
  output rbd_pkg::state_t    state
);

  rbd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    rsp_valid  = 1'b0;
    ctrl.load  = 1'b0;
    ctrl.exec  = 1'b0;
    case (state)
      rbd_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctrl.load  = 1'b1;
          state_next = rbd_pkg::S_EXEC;
        end
      end
      rbd_pkg::S_EXEC: begin
        ctrl.exec  = 1'b1;
        state_next = rbd_pkg::S_RESP;
      end
      rbd_pkg::S_RESP: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_next = rbd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rbd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/rbd_datapath.sv =====
// Datapath of the ring buffer deque: ring memory, front and back pointers,
// overwrite register and result registers. Depends on rbd_pkg.

module rbd_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  rbd_pkg::ctrl_cmd_t                ctrl,
  input  logic                              cfg_we,
  input  logic                              cfg_wdata,
  input  logic [rbd_pkg::CMD_BITS-1:0]      cmd,
  input  logic [rbd_pkg::VALUE_BITS-1:0]    value,
  input  logic [rbd_pkg::POS_BITS-1:0]      position,
  output logic [rbd_pkg::VALUE_BITS-1:0]    read_value,
  output logic [rbd_pkg::STATUS_BITS-1:0]   status,
  output logic                              dropped,
  output logic [rbd_pkg::COUNT_BITS-1:0]    count,
  output logic                              is_full,
  output logic                              is_empty
);

  localparam int RING_SLOTS = rbd_pkg::RING_SLOTS;
  localparam int WORD_BITS  = rbd_pkg::WORD_BITS;
  localparam int PTR_W = $clog2(RING_SLOTS);
  localparam int CNT_W = (PTR_W > rbd_pkg::COUNT_BITS) ? PTR_W : rbd_pkg::COUNT_BITS;
  localparam int SUM_W = ((PTR_W > rbd_pkg::POS_BITS) ? PTR_W : rbd_pkg::POS_BITS) + 1;
  localparam int EXT_W = 64;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(RING_SLOTS - 1);

  logic [WORD_BITS-1:0] ring_store [RING_SLOTS];

  logic [PTR_W-1:0]                  front_ptr;
  logic [PTR_W-1:0]                  back_ptr;
  logic [PTR_W-1:0]                  front_ptr_next;
  logic [PTR_W-1:0]                  back_ptr_next;
  logic                              overwrite_enable;
  logic [rbd_pkg::CMD_BITS-1:0]      cmd_q;
  logic [WORD_BITS-1:0]              word_q;
  logic [rbd_pkg::POS_BITS-1:0]      pos_q;
  logic [WORD_BITS-1:0]              rdata;
  logic                              rd_sel;
  logic                              rd_sel_next;
  rbd_pkg::status_t                  status_q;
  rbd_pkg::status_t                  status_next;
  logic                              dropped_q;
  logic                              dropped_next;
  logic                              we;
  logic [PTR_W-1:0]                  waddr;
  logic [PTR_W-1:0]                  raddr;
  logic [PTR_W-1:0]                  held;
  logic [PTR_W-1:0]                  front_inc;
  logic [PTR_W-1:0]                  front_dec;
  logic [PTR_W-1:0]                  back_inc;
  logic [PTR_W-1:0]                  back_dec;
  logic                              full;
  logic                              empty;
  logic [SUM_W-1:0]                  idx_sum;
  logic [SUM_W-1:0]                  idx_wrap;
  logic [EXT_W-1:0]                  value_ext;
  logic [EXT_W-1:0]                  rdata_ext;
  logic [CNT_W-1:0]                  held_ext;
  logic [PTR_W:0]                    diff;

  assign diff      = {1'b0, back_ptr} + (PTR_W + 1)'(RING_SLOTS) - {1'b0, front_ptr};
  assign held      = (back_ptr >= front_ptr) ? (back_ptr - front_ptr) : diff[PTR_W-1:0];
  assign full      = (held == LAST);
  assign empty     = (held == '0);
  assign front_inc = (front_ptr == LAST) ? '0 : front_ptr + 1'b1;
  assign front_dec = (front_ptr == '0) ? LAST : front_ptr - 1'b1;
  assign back_inc  = (back_ptr == LAST) ? '0 : back_ptr + 1'b1;
  assign back_dec  = (back_ptr == '0) ? LAST : back_ptr - 1'b1;
  assign idx_sum   = SUM_W'(front_ptr) + SUM_W'(pos_q);
  assign idx_wrap  = (idx_sum >= SUM_W'(RING_SLOTS)) ? idx_sum - SUM_W'(RING_SLOTS) : idx_sum;
  assign value_ext = EXT_W'(value);

  always_ff @(posedge clk) begin
    if (rst) begin
      overwrite_enable <= 1'b0;
    end else if (cfg_we) begin
      overwrite_enable <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q  <= cmd;
      word_q <= value_ext[WORD_BITS-1:0];
      pos_q  <= position;
    end
  end

  always_comb begin
    front_ptr_next = front_ptr;
    back_ptr_next  = back_ptr;
    status_next    = rbd_pkg::ST_OK;
    dropped_next   = 1'b0;
    rd_sel_next    = 1'b0;
    we             = 1'b0;
    waddr          = back_ptr;
    raddr          = front_ptr;
    case (rbd_pkg::cmd_t'(cmd_q))
      rbd_pkg::CMD_PUSH_BACK: begin
        if (full && !overwrite_enable) begin
          status_next = rbd_pkg::ST_FULL;
        end else begin
          if (full) begin
            front_ptr_next = front_inc;
            dropped_next   = 1'b1;
          end
          we            = 1'b1;
          waddr         = back_ptr;
          back_ptr_next = back_inc;
        end
      end
      rbd_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          status_next = rbd_pkg::ST_EMPTY;
        end else begin
          rd_sel_next    = 1'b1;
          raddr          = front_ptr;
          front_ptr_next = front_inc;
        end
      end
      rbd_pkg::CMD_PUSH_FRONT: begin
        if (full && !overwrite_enable) begin
          status_next = rbd_pkg::ST_FULL;
        end else begin
          if (full) begin
            back_ptr_next = back_dec;
            dropped_next  = 1'b1;
          end
          we             = 1'b1;
          waddr          = front_dec;
          front_ptr_next = front_dec;
        end
      end
      rbd_pkg::CMD_POP_BACK: begin
        if (empty) begin
          status_next = rbd_pkg::ST_EMPTY;
        end else begin
          rd_sel_next   = 1'b1;
          raddr         = back_dec;
          back_ptr_next = back_dec;
        end
      end
      rbd_pkg::CMD_READ_INDEX: begin
        if (SUM_W'(pos_q) >= SUM_W'(held)) begin
          status_next = rbd_pkg::ST_RANGE;
        end else begin
          rd_sel_next = 1'b1;
          raddr       = idx_wrap[PTR_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec && we) begin
      ring_store[waddr] <= word_q;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      rdata <= ring_store[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_ptr <= '0;
      back_ptr  <= '0;
    end else if (ctrl.exec) begin
      front_ptr <= front_ptr_next;
      back_ptr  <= back_ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      status_q  <= status_next;
      dropped_q <= dropped_next;
      rd_sel    <= rd_sel_next;
    end
  end

  assign rdata_ext  = EXT_W'(rdata);
  assign held_ext   = CNT_W'(held);
  assign read_value = rd_sel ? rdata_ext[rbd_pkg::VALUE_BITS-1:0] : '0;
  assign status     = status_q;
  assign dropped    = dropped_q;
  assign count      = held_ext[rbd_pkg::COUNT_BITS-1:0];
  assign is_full    = full;
  assign is_empty   = empty;

endmodule

// ===== hdl/ring_buffer_deque.sv =====
// Top level of the ring buffer deque: controller plus datapath behind two
// handshake channels. Depends on rbd_pkg, rbd_if, rbd_ctrl and rbd_datapath.
//
//   channel  dir  payload                                           accept
//   req      in   cmd, value, position                              valid & ready
//   rsp      out  read_value, status, dropped, count, full, empty   valid & ready
//   cfg      in   overwrite_enable (cfg_wdata)                      cfg_we
//
// An item passes through accept, execute (pointer update, ring write,
// registered ring read), then the result state. req.ready is high only
// when no item is held. A stalled result stays in its registers until
// rsp.ready. Reset clears the pointers, the overwrite register and the
// controller; ring contents are not cleared.

module ring_buffer_deque (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  rbd_req_if.sink  req,
  rbd_rsp_if.source rsp
);

  rbd_pkg::ctrl_cmd_t ctrl;
  rbd_pkg::state_t    state;

  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .ctrl      (ctrl),
    .state     (state)
  );

  rbd_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (req.cmd),
    .value      (req.value),
    .position   (req.position),
    .read_value (rsp.read_value),
    .status     (rsp.status),
    .dropped    (rsp.dropped),
    .count      (rsp.count),
    .is_full    (rsp.is_full),
    .is_empty   (rsp.is_empty)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid))
    else $error("req ready while a result is held");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |-> ##2 (rsp.valid && state == rbd_pkg::S_RESP))
    else $error("result not presented two cycles after accept");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.dropped) |-> (rsp.is_full && rsp.status == rbd_pkg::ST_OK))
    else $error("overwriting push did not leave the queue full");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.is_empty) |-> (rsp.count == '0))
    else $error("empty result with nonzero count");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for ring_buffer_deque: random and directed commands
// against a scoreboard that tracks the queue. Depends on rbd_pkg and rbd_if.

module testbench;

  localparam logic [rbd_pkg::COUNT_BITS-1:0] CAPACITY = 4'd15;
  localparam logic [rbd_pkg::CMD_BITS-1:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [rbd_pkg::CMD_BITS-1:0] CMD_LAST_CODE = 3'd7;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 380;

  typedef enum {TILT_FILL, TILT_DRAIN, TILT_MIX} tilt_t;

  typedef struct {
    logic [rbd_pkg::VALUE_BITS-1:0] read_value;
    rbd_pkg::status_t               status;
    logic                           dropped;
    logic [rbd_pkg::COUNT_BITS-1:0] count;
    logic                           is_full;
    logic                           is_empty;
  } deque_result_t;

  class deque_scoreboard;
    logic [rbd_pkg::VALUE_BITS-1:0] ring [16];
    logic [rbd_pkg::COUNT_BITS-1:0] front_idx;
    logic [rbd_pkg::COUNT_BITS-1:0] back_idx;
    bit overwrite_on;
    deque_result_t expected_q[$];
    int errors, checked, commands, drops, full_rejects, empty_pops, range_misses;

    function new();
      front_idx = '0;
      back_idx = '0;
      overwrite_on = 1'b0;
      errors = 0;
      checked = 0;
      commands = 0;
      drops = 0;
      full_rejects = 0;
      empty_pops = 0;
      range_misses = 0;
    endfunction

    function logic [rbd_pkg::COUNT_BITS-1:0] held();
      return back_idx - front_idx;
    endfunction

    function void note_command(logic [rbd_pkg::CMD_BITS-1:0] c,
                               logic [rbd_pkg::VALUE_BITS-1:0] v,
                               logic [rbd_pkg::POS_BITS-1:0] p);
      deque_result_t r;
      logic [rbd_pkg::COUNT_BITS-1:0] n;
      logic [rbd_pkg::COUNT_BITS-1:0] slot;
      n = held();
      r.read_value = '0;
      r.status = rbd_pkg::ST_OK;
      r.dropped = 1'b0;
      commands++;
      case (c)
        rbd_pkg::CMD_PUSH_BACK: begin
          if (n == CAPACITY && !overwrite_on) begin
            r.status = rbd_pkg::ST_FULL;
            full_rejects++;
          end else begin
            if (n == CAPACITY) begin
              front_idx++;
              r.dropped = 1'b1;
              drops++;
            end
            ring[back_idx] = v;
            back_idx++;
          end
        end
        rbd_pkg::CMD_PUSH_FRONT: begin
          if (n == CAPACITY && !overwrite_on) begin
            r.status = rbd_pkg::ST_FULL;
            full_rejects++;
          end else begin
            if (n == CAPACITY) begin
              back_idx--;
              r.dropped = 1'b1;
              drops++;
            end
            front_idx--;
            ring[front_idx] = v;
          end
        end
        rbd_pkg::CMD_POP_FRONT: begin
          if (n == 0) begin
            r.status = rbd_pkg::ST_EMPTY;
            empty_pops++;
          end else begin
            r.read_value = ring[front_idx];
            front_idx++;
          end
        end
        rbd_pkg::CMD_POP_BACK: begin
          if (n == 0) begin
            r.status = rbd_pkg::ST_EMPTY;
            empty_pops++;
          end else begin
            back_idx--;
            r.read_value = ring[back_idx];
          end
        end
        rbd_pkg::CMD_READ_INDEX: begin
          if (p >= n) begin
            r.status = rbd_pkg::ST_RANGE;
            range_misses++;
          end else begin
            slot = front_idx + p;
            r.read_value = ring[slot];
          end
        end
        default: begin
        end
      endcase
      r.count = held();
      r.is_full = (r.count == CAPACITY);
      r.is_empty = (r.count == 0);
      expected_q.push_back(r);
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
    endfunction

    function void check_result(deque_result_t got);
      deque_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: read_value 0x%0h status %0d count %0d",
                 $time, got.read_value, got.status, got.count);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare_field("read_value", want.read_value, got.read_value);
      compare_field("status", want.status, got.status);
      compare_field("dropped", want.dropped, got.dropped);
      compare_field("count", want.count, got.count);
      compare_field("is_full", want.is_full, got.is_full);
      compare_field("is_empty", want.is_empty, got.is_empty);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  int idle_pct;
  int stall_pct;
  int hold_requests;
  int holds_done;
  deque_scoreboard tracker = new();

  rbd_req_if req_ch();
  rbd_rsp_if rsp_ch();

  ring_buffer_deque dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 200000);
    $display("ring_buffer_deque: mismatch");
    $finish;
  end

  initial begin
    rsp_ch.ready = 1'b0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holds_done++;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    deque_result_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.read_value = rsp_ch.read_value;
      got.status = rbd_pkg::status_t'(rsp_ch.status);
      got.dropped = rsp_ch.dropped;
      got.count = rsp_ch.count;
      got.is_full = rsp_ch.is_full;
      got.is_empty = rsp_ch.is_empty;
      tracker.check_result(got);
    end
  end

  task automatic send_command(logic [rbd_pkg::CMD_BITS-1:0] c,
                              logic [rbd_pkg::VALUE_BITS-1:0] v,
                              logic [rbd_pkg::POS_BITS-1:0] p);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= c;
    req_ch.value <= v;
    req_ch.position <= p;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    tracker.note_command(c, v, p);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (tracker.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_overwrite(bit enable);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= enable;
    tracker.overwrite_on = enable;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random_commands(int n);
    tilt_t tilt;
    int push_pct;
    int pop_pct;
    int r;
    logic [rbd_pkg::CMD_BITS-1:0] c;
    logic [rbd_pkg::VALUE_BITS-1:0] v;
    logic [rbd_pkg::POS_BITS-1:0] p;
    tilt = TILT_MIX;
    for (int i = 0; i < n; i++) begin
      if (i % 30 == 0) tilt = tilt_t'($urandom_range(2));
      case (tilt)
        TILT_FILL: begin
          push_pct = 70;
          pop_pct = 16;
        end
        TILT_DRAIN: begin
          push_pct = 20;
          pop_pct = 60;
        end
        default: begin
          push_pct = 40;
          pop_pct = 34;
        end
      endcase
      r = $urandom_range(99);
      if (r < push_pct) begin
        c = $urandom_range(1) ? rbd_pkg::CMD_PUSH_FRONT : rbd_pkg::CMD_PUSH_BACK;
      end else if (r < push_pct + pop_pct) begin
        c = $urandom_range(1) ? rbd_pkg::CMD_POP_FRONT : rbd_pkg::CMD_POP_BACK;
      end else if (r < 97) begin
        c = rbd_pkg::CMD_READ_INDEX;
      end else begin
        c = 3'($urandom_range(CMD_LAST_CODE, CMD_FIRST_UNUSED));
      end
      r = $urandom_range(99);
      if (r < 5) v = '0;
      else if (r < 10) v = '1;
      else v = $urandom;
      if ($urandom_range(3) == 0 || tracker.held() == 0) p = 4'($urandom_range(15));
      else p = 4'($urandom_range(tracker.held() - 1));
      send_command(c, v, p);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.cmd = '0;
    req_ch.value = '0;
    req_ch.position = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_requests = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_overwrite(1'b0);
    send_command(rbd_pkg::CMD_POP_FRONT, $urandom, 4'd0);
    send_command(rbd_pkg::CMD_POP_BACK, $urandom, 4'd0);
    send_command(rbd_pkg::CMD_READ_INDEX, $urandom, 4'd0);
    send_command(CMD_LAST_CODE, '1, 4'd15);
    send_command(rbd_pkg::CMD_PUSH_BACK, 32'hFFFF_FFFF, 4'd15);
    send_command(rbd_pkg::CMD_PUSH_FRONT, 32'h0, 4'd0);
    send_command(rbd_pkg::CMD_READ_INDEX, $urandom, 4'd1);
    send_command(rbd_pkg::CMD_READ_INDEX, $urandom, 4'd2);
    send_command(rbd_pkg::CMD_POP_BACK, $urandom, 4'd0);
    send_command(rbd_pkg::CMD_POP_FRONT, $urandom, 4'd0);
    for (int i = 0; i < 15; i++)
      send_command(i[0] ? rbd_pkg::CMD_PUSH_FRONT : rbd_pkg::CMD_PUSH_BACK, $urandom, 4'd0);
    send_command(rbd_pkg::CMD_PUSH_BACK, $urandom, 4'd0);
    send_command(rbd_pkg::CMD_PUSH_FRONT, $urandom, 4'd0);
    send_command(rbd_pkg::CMD_READ_INDEX, $urandom, 4'd14);
    send_command(rbd_pkg::CMD_READ_INDEX, $urandom, 4'd15);
    write_overwrite(1'b1);
    send_command(rbd_pkg::CMD_PUSH_BACK, $urandom, 4'd0);
    send_command(rbd_pkg::CMD_PUSH_FRONT, $urandom, 4'd0);
    send_command(CMD_FIRST_UNUSED, $urandom, 4'd0);

    run_random_commands(PHASE_ITEMS);
    write_overwrite(1'b0);
    idle_pct = 85;
    run_random_commands(PHASE_ITEMS);
    write_overwrite(1'b1);
    idle_pct = 0;
    stall_pct = 85;
    run_random_commands(PHASE_ITEMS);
    write_overwrite(1'b0);
    idle_pct = 13;
    stall_pct = 13;
    run_random_commands(PHASE_ITEMS);

    // hold the result side while items keep being offered
    write_overwrite(1'b1);
    idle_pct = 0;
    stall_pct = 0;
    hold_requests++;
    run_random_commands(30);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("ran %0d commands under overwrite on and off: %0d drops, %0d rejected pushes",
             tracker.commands, tracker.drops, tracker.full_rejects);
    $display("%0d pops on empty, %0d out-of-range reads, %0d results checked",
             tracker.empty_pops, tracker.range_misses, tracker.checked);
    if (tracker.errors == 0 && tracker.expected_q.size() == 0) begin
      $display("ring_buffer_deque: match");
    end else begin
      $display("ring_buffer_deque: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rbd_pkg.sv
hdl/rbd_if.sv
hdl/rbd_ctrl.sv
hdl/rbd_datapath.sv
hdl/ring_buffer_deque.sv
sim/testbench.sv
